// ===== rtl/heightmap_bilinear_sampler_macros.svh =====
// assertion macros for the heightmap bilinear sampler
// included by rtl files that carry concurrent assertions, needs no package
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH

// property checked on every rising edge outside reset
`define HBS_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition that must never be true outside reset
`define HBS_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== rtl/hbs_pkg.sv =====
// shared constants and types for the heightmap bilinear sampler
// no dependencies
`default_nettype none

package hbs_pkg;

    localparam int HBS_MAX_GRID = 256;

    localparam int HEIGHT_W  = 16;
    localparam int WORLD_W   = 20;
    localparam int COORD_W   = 8;
    localparam int SCALE_W   = 24;
    localparam int SIZE_W    = 9;
    localparam int FRAC_W    = 8;
    localparam int S_DATA_W  = 72;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 24;

    typedef logic signed [HEIGHT_W-1:0] height_t;

    // command kinds carried on s_tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_SIZE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_SCALE = 1'b1;

    localparam logic [SIZE_W-1:0]  GRID_SIZE_RESET  = 9'd256;
    localparam logic [SCALE_W-1:0] GRID_SCALE_RESET = 24'd65536;

endpackage

`default_nettype wire

// ===== rtl/hbs_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module hbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/heightmap_bilinear_sampler.sv =====
// a query reaches m_tvalid through every stage register and the output register
// throughput: one item per cycle unless the output stalls; the four neighbor reads
// hit four parity banks (one read port each); writes share stage 3 so order is kept
// reset: clears pipeline valids and sets grid_size 256, grid_scale 65536
// the height store is not cleared; entries hold garbage until written
`default_nettype none
`include "heightmap_bilinear_sampler_macros.svh"

module heightmap_bilinear_sampler #(
    parameter int MAX_GRID = hbs_pkg::HBS_MAX_GRID
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [hbs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [hbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // col[7:0], row[15:8], height_in[31:16], world_x[51:32], world_z[71:52]
    input  wire logic [hbs_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd[0]
    input  wire logic                           s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // height_out[15:0]
    output logic [hbs_pkg::HEIGHT_W-1:0]        m_tdata
);

    import hbs_pkg::*;

    localparam int IW    = (MAX_GRID > 2) ? $clog2(MAX_GRID) : 1;
    localparam int GXW   = IW + FRAC_W;
    localparam int HALF  = (MAX_GRID + 1) / 2;
    localparam int BANK_DEPTH = HALF * HALF;
    localparam int AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int PROD_W = WORLD_W + SCALE_W + 1;
    localparam int SUM_W  = PROD_W - 16 + 1;
    localparam int BP_W   = HEIGHT_W + 1 + FRAC_W + 1;

    function automatic logic [AW-1:0] bank_addr(input logic [IW-1:0] c,
                                                 input logic [IW-1:0] r);
        bank_addr = AW'((32'(r) >> 1) * HALF + (32'(c) >> 1));
    endfunction

    // configuration registers
    logic [SIZE_W-1:0]  grid_size_reg;
    logic [SCALE_W-1:0] grid_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg  <= GRID_SIZE_RESET;
            grid_scale_reg <= GRID_SCALE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_GRID_SIZE:  grid_size_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_GRID_SCALE: grid_scale_reg <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // last grid index in use
    logic [IW-1:0] gm1;
    always_comb begin
        if (grid_size_reg < 9'd2) begin
            gm1 = IW'(1);
        end else if (32'(grid_size_reg) > MAX_GRID) begin
            gm1 = IW'(MAX_GRID - 1);
        end else begin
            gm1 = IW'(grid_size_reg - 9'd1);
        end
    end

    // pipeline valids and stall chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, m_tvalid_reg;
    logic free1, free2, free3, free4, free5, free6, free_out;

    logic cmd2_reg;

    assign free_out = !m_tvalid_reg || m_tready;
    assign free6    = !v6_reg || free_out;
    assign free5    = !v5_reg || free6;
    assign free4    = !v4_reg || free5;
    assign free3    = !v3_reg || free4;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign s_tready = free1;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (free1)    v1_reg       <= s_tvalid;
            if (free2)    v2_reg       <= v1_reg;
            if (free3)    v3_reg       <= v2_reg && (cmd2_reg == CMD_QUERY);
            if (free4)    v4_reg       <= v3_reg;
            if (free5)    v5_reg       <= v4_reg;
            if (free6)    v6_reg       <= v5_reg;
            if (free_out) m_tvalid_reg <= v6_reg;
        end
    end

    // stage 1: world position times scale
    logic                      cmd1_reg;
    logic [COORD_W-1:0]        col1_reg, row1_reg;
    height_t                   hin1_reg;
    logic signed [PROD_W-1:0]  px1_reg, pz1_reg;
    logic signed [PROD_W-1:0]  px_next, pz_next;

    assign px_next = $signed(s_tdata[51:32]) * $signed({1'b0, grid_scale_reg});
    assign pz_next = $signed(s_tdata[71:52]) * $signed({1'b0, grid_scale_reg});

    always_ff @(posedge aclk) begin
        if (free1) begin
            cmd1_reg <= s_tuser;
            col1_reg <= s_tdata[7:0];
            row1_reg <= s_tdata[15:8];
            hin1_reg <= s_tdata[31:16];
            px1_reg  <= px_next;
            pz1_reg  <= pz_next;
        end
    end

    // stage 2: floor, recenter and clamp to grid space
    logic signed [SUM_W-1:0] off2, top2, cx2, cz2;
    logic [GXW-1:0]          gx_next, gz_next;

    assign off2 = signed'(SUM_W'({gm1, 7'd0}));
    assign top2 = signed'(SUM_W'({gm1, 8'd0}));
    assign cx2  = SUM_W'(signed'(px1_reg[PROD_W-1:16])) + off2;
    assign cz2  = SUM_W'(signed'(pz1_reg[PROD_W-1:16])) + off2;

    always_comb begin
        if (cx2 < 0)         gx_next = '0;
        else if (cx2 > top2) gx_next = GXW'(top2);
        else                 gx_next = GXW'(cx2);
        if (cz2 < 0)         gz_next = '0;
        else if (cz2 > top2) gz_next = GXW'(top2);
        else                 gz_next = GXW'(cz2);
    end

    logic [COORD_W-1:0] col2_reg, row2_reg;
    height_t            hin2_reg;
    logic [GXW-1:0]     gx2_reg, gz2_reg;

    always_ff @(posedge aclk) begin
        if (free2) begin
            cmd2_reg <= cmd1_reg;
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
            hin2_reg <= hin1_reg;
            gx2_reg  <= gx_next;
            gz2_reg  <= gz_next;
        end
    end

    // stage 3: bank access, writes and reads in item order
    logic [IW-1:0] i0, i1, j0, j1, wc, wr;
    logic          wr_in_range, ram_re, wr_go;

    assign i0 = gx2_reg[GXW-1:FRAC_W];
    assign j0 = gz2_reg[GXW-1:FRAC_W];
    assign i1 = (i0 == gm1) ? i0 : i0 + 1'b1;
    assign j1 = (j0 == gm1) ? j0 : j0 + 1'b1;
    assign wc = IW'(32'(col2_reg));
    assign wr = IW'(32'(row2_reg));
    assign wr_in_range = (32'(col2_reg) < MAX_GRID) && (32'(row2_reg) < MAX_GRID);
    assign ram_re = v2_reg && (cmd2_reg == CMD_QUERY) && free3;
    assign wr_go  = v2_reg && (cmd2_reg == CMD_WRITE) && free3 && wr_in_range;

    logic [HEIGHT_W-1:0] bank_rd [4];
    logic [3:0]          bank_we;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PC = 1'(b % 2);
        localparam logic PR = 1'(b / 2);
        logic [IW-1:0] rc, rr;

        assign rc = (i0[0] == PC) ? i0 : i1;
        assign rr = (j0[0] == PR) ? j0 : j1;
        assign bank_we[b] = wr_go && (wc[0] == PC) && (wr[0] == PR);

        hbs_ram #(
            .WIDTH (HEIGHT_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .aclk  (aclk),
            .we    (bank_we[b]),
            .waddr (bank_addr(wc, wr)),
            .wdata (hin2_reg),
            .re    (ram_re),
            .raddr (bank_addr(rc, rr)),
            .rdata (bank_rd[b])
        );
    end

    logic              i0p3_reg, i1p3_reg, j0p3_reg, j1p3_reg;
    logic [FRAC_W-1:0] tx3_reg, tz3_reg;

    always_ff @(posedge aclk) begin
        if (free3) begin
            i0p3_reg <= i0[0];
            i1p3_reg <= i1[0];
            j0p3_reg <= j0[0];
            j1p3_reg <= j1[0];
            tx3_reg  <= gx2_reg[FRAC_W-1:0];
            tz3_reg  <= gz2_reg[FRAC_W-1:0];
        end
    end

    // stage 4: x blend products for both rows
    height_t                 a0, b0, a1, b1;
    logic signed [HEIGHT_W:0] dx0, dx1;
    logic signed [BP_W-1:0]  px0_next, px1_next;

    assign a0  = bank_rd[{j0p3_reg, i0p3_reg}];
    assign b0  = bank_rd[{j0p3_reg, i1p3_reg}];
    assign a1  = bank_rd[{j1p3_reg, i0p3_reg}];
    assign b1  = bank_rd[{j1p3_reg, i1p3_reg}];
    assign dx0 = {b0[15], b0} - {a0[15], a0};
    assign dx1 = {b1[15], b1} - {a1[15], a1};
    assign px0_next = dx0 * $signed({1'b0, tx3_reg});
    assign px1_next = dx1 * $signed({1'b0, tx3_reg});

    height_t                a0_4_reg, a1_4_reg;
    logic [BP_W-1:0]        p0_4_reg, p1_4_reg;
    logic [FRAC_W-1:0]      tz4_reg;

    always_ff @(posedge aclk) begin
        if (free4) begin
            a0_4_reg <= a0;
            a1_4_reg <= a1;
            p0_4_reg <= px0_next;
            p1_4_reg <= px1_next;
            tz4_reg  <= tz3_reg;
        end
    end

    // stage 5: finish x blends, the result stays between its two corners
    logic [HEIGHT_W+1:0] s0, s1;

    assign s0 = {{2{a0_4_reg[15]}}, a0_4_reg} + p0_4_reg[BP_W-1:FRAC_W];
    assign s1 = {{2{a1_4_reg[15]}}, a1_4_reg} + p1_4_reg[BP_W-1:FRAC_W];

    height_t           h0_5_reg, h1_5_reg;
    logic [FRAC_W-1:0] tz5_reg;

    always_ff @(posedge aclk) begin
        if (free5) begin
            h0_5_reg <= s0[HEIGHT_W-1:0];
            h1_5_reg <= s1[HEIGHT_W-1:0];
            tz5_reg  <= tz4_reg;
        end
    end

    // stage 6: z blend product
    logic signed [HEIGHT_W:0] dz;
    logic signed [BP_W-1:0]   pz_blend_next;

    assign dz = {h1_5_reg[15], h1_5_reg} - {h0_5_reg[15], h0_5_reg};
    assign pz_blend_next = dz * $signed({1'b0, tz5_reg});

    height_t         h0_6_reg;
    logic [BP_W-1:0] p2_6_reg;

    always_ff @(posedge aclk) begin
        if (free6) begin
            h0_6_reg <= h0_5_reg;
            p2_6_reg <= pz_blend_next;
        end
    end

    // output register
    logic [HEIGHT_W+1:0] s_out;
    logic [HEIGHT_W-1:0] m_tdata_reg;

    assign s_out = {{2{h0_6_reg[15]}}, h0_6_reg} + p2_6_reg[BP_W-1:FRAC_W];

    always_ff @(posedge aclk) begin
        if (free_out) begin
            m_tdata_reg <= s_out[HEIGHT_W-1:0];
        end
    end

    assign m_tdata = m_tdata_reg;

    `HBS_ASSERT_CLK(a_accept_fills_s1, aclk, aresetn, (s_tvalid && s_tready) |=> v1_reg, "accepted transfer lost at stage 1")
    `HBS_ASSERT_CLK(a_read_fills_s3, aclk, aresetn, ram_re |=> v3_reg, "bank read without stage 3 item")
    `HBS_ASSERT_NEVER(a_no_read_and_write, aclk, aresetn, ram_re && (bank_we != 4'b0000), "bank read and write in one cycle")
    `HBS_ASSERT_CLK(a_s6_to_out, aclk, aresetn, (v6_reg && free_out) |=> m_tvalid_reg, "result dropped before output register")

endmodule

`default_nettype wire
